FILE: rtl/bte_pkg.sv
// Shared types and constants for the boosted tree ensemble scorer.
`default_nettype none
package bte_pkg;
    localparam int unsigned SCORE_W = 48;

    typedef enum logic [1:0] {
        KIND_NODE    = 2'd0,
        KIND_RANGE   = 2'd1,
        KIND_FEATURE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // ST_TERM marks a scaled leaf waiting to be added; it never reaches a result.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_LEAF    = 3'd1,
        ST_BAD_SPLIT   = 3'd2,
        ST_CHILD_RANGE = 3'd3,
        ST_NO_LEAF     = 3'd4,
        ST_TREE_RANGE  = 3'd5,
        ST_FEAT_COUNT  = 3'd6,
        ST_TERM        = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CFG_INIT   = 2'd0,
        CFG_RATE   = 2'd1,
        CFG_THRESH = 2'd2,
        CFG_TREES  = 2'd3
    } cfg_addr_t;

    typedef enum logic [2:0] {
        EV_IDLE,
        EV_TREE_RD,
        EV_TREE_CHK,
        EV_NODE_RD,
        EV_NODE_CHK,
        EV_SCALE,
        EV_ACCUM,
        EV_DONE
    } ev_state_t;

    // Command from the front part to the evaluator: the count check result.
    typedef struct packed {
        logic count_ok;
    } eval_cmd_t;

    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0] s;
        s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (s[SCORE_W] != s[SCORE_W-1]) begin
            sat_add = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            sat_add = s[SCORE_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

FILE: rtl/bte_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module bte_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/bte_front.sv
// Front part: accepts items, writes features, queues evaluations; the top writes the tables.
`default_nettype none
module bte_front #(
    parameter int unsigned NUM_FEATURES = 27
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_kind,
    input  wire logic                  s_last,
    input  wire logic [11:0]           s_index,
    output logic                       feat_we,
    output logic                       q_valid,
    output bte_pkg::eval_cmd_t         q_cmd,
    input  wire logic                  q_ready,
    input  wire logic                  eval_busy
);
    import bte_pkg::*;

    logic [5:0] seen_reg, seen_next;
    logic       q_valid_reg;
    eval_cmd_t  q_cmd_reg;
    logic       acc;
    logic       is_feat;

    // Single-entry queue; hold off loads while a walk reads the tables.
    assign s_ready = !q_valid_reg && !eval_busy;
    assign acc     = s_valid && s_ready;
    assign is_feat = kind_t'(s_kind) == KIND_FEATURE;
    assign feat_we = acc && is_feat && (32'(s_index) < NUM_FEATURES);
    assign q_valid = q_valid_reg;
    assign q_cmd   = q_cmd_reg;

    always_comb begin
        seen_next = seen_reg;
        if (acc && is_feat) begin
            if (seen_reg != 6'd63) begin
                seen_next = seen_reg + 6'd1;
            end
            if (s_last) begin
                seen_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            seen_reg <= seen_next;
            if (acc && is_feat && s_last) begin
                q_valid_reg <= 1'b1;
            end else if (q_ready) begin
                q_valid_reg <= 1'b0;
            end
        end
    end

    // The count saturates at 63 before the compare.
    always_ff @(posedge aclk) begin
        if (acc && is_feat && s_last) begin
            q_cmd_reg.count_ok <= (seen_reg == 6'd63 ? 32'd63 : 32'(seen_reg) + 32'd1) ==
                                  NUM_FEATURES;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/bte_eval.sv
// Back part: walks each configured tree in turn and accumulates the scaled leaf values, stopping at the first fault.
`default_nettype none
module bte_eval #(
    parameter int unsigned NODE_DEPTH   = 4096,
    parameter int unsigned MAX_TREES    = 256,
    parameter int unsigned NUM_FEATURES = 27
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire bte_pkg::eval_cmd_t          q_cmd,
    output logic                             q_ready,
    output logic                             busy,
    input  wire logic signed [47:0]          initial_score,
    input  wire logic [16:0]                 leaf_scale,
    input  wire logic [8:0]                  num_trees,
    output logic [$clog2(MAX_TREES)-1:0]     tree_raddr,
    input  wire logic [12:0]                 tree_first,
    input  wire logic [12:0]                 tree_total,
    output logic [$clog2(NODE_DEPTH)-1:0]    node_raddr,
    input  wire logic signed [15:0]          node_left,
    input  wire logic signed [15:0]          node_right,
    input  wire logic signed [7:0]           node_feat,
    input  wire logic signed [31:0]          node_thresh,
    input  wire logic signed [31:0]          node_value,
    output logic [$clog2(NUM_FEATURES)-1:0]  feat_raddr,
    input  wire logic signed [31:0]          feat_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [47:0]               res_score,
    output logic [2:0]                       res_status
);
    import bte_pkg::*;
    localparam int unsigned NW = $clog2(NODE_DEPTH);
    localparam int unsigned TW = $clog2(MAX_TREES);
    localparam int unsigned FW = $clog2(NUM_FEATURES);

    ev_state_t state_reg, state_next;
    logic [8:0]  tree_reg, tree_next;
    logic [16:0] first_reg, first_next;
    logic [12:0] total_reg, total_next;
    logic [12:0] visit_reg, visit_next;
    logic [15:0] at_reg, at_next;
    logic signed [47:0] sum_reg, sum_next;
    logic signed [31:0] leaf_reg, leaf_next;
    logic signed [49:0] prod_reg, prod_next;
    logic        out_valid_reg, out_valid_next;
    logic signed [47:0] out_score_reg, out_score_next;
    logic [2:0]  out_st_reg, out_st_next;
    logic [16:0] node_addr;
    logic        le;
    logic signed [15:0] nx;

    assign node_addr  = first_reg + 17'(at_reg);
    assign node_raddr = node_addr[NW-1:0];
    assign tree_raddr = TW'(tree_reg);
    // Feature read needs the split's slot; the read is registered, so its data is used in the next cycle.
    assign feat_raddr = FW'(node_feat[FW-1:0] < NUM_FEATURES ? node_feat[FW-1:0] : '0);
    assign le         = feat_value <= node_thresh;
    assign nx         = le ? node_left : node_right;
    assign q_ready    = state_reg == EV_IDLE && !out_valid_reg;
    assign busy       = state_reg != EV_IDLE;
    assign m_valid    = out_valid_reg;
    assign res_score  = out_score_reg;
    assign res_status = out_st_reg;

    always_comb begin
        logic signed [49:0] t;
        state_next     = state_reg;
        tree_next      = tree_reg;
        first_next     = first_reg;
        total_next     = total_reg;
        visit_next     = visit_reg;
        at_next        = at_reg;
        sum_next       = sum_reg;
        leaf_next      = leaf_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_score_next = out_score_reg;
        out_st_next    = out_st_reg;
        t              = '0;
        unique case (state_reg)
            EV_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    tree_next = '0;
                    sum_next  = initial_score;
                    if (!q_cmd.count_ok) begin
                        out_valid_next = 1'b1;
                        out_score_next = '0;
                        out_st_next    = ST_FEAT_COUNT;
                    end else begin
                        state_next = EV_TREE_RD;
                    end
                end
            end
            EV_TREE_RD: begin
                if (tree_reg >= num_trees) begin
                    state_next  = EV_DONE;
                    out_st_next = ST_OK;
                end else if (32'(tree_reg) >= MAX_TREES) begin
                    state_next  = EV_DONE;
                    out_st_next = ST_TREE_RANGE;
                end else begin
                    state_next = EV_TREE_CHK;
                end
            end
            EV_TREE_CHK: begin
                first_next = 17'(tree_first);
                total_next = tree_total;
                visit_next = '0;
                at_next    = '0;
                if (tree_total == '0 || 32'(tree_first) > NODE_DEPTH ||
                    32'(tree_total) > NODE_DEPTH - 32'(tree_first)) begin
                    state_next  = EV_DONE;
                    out_st_next = ST_TREE_RANGE;
                end else begin
                    state_next = EV_NODE_RD;
                end
            end
            EV_NODE_RD: begin
                if (visit_reg >= total_reg) begin
                    state_next  = EV_DONE;
                    out_st_next = ST_NO_LEAF;
                end else begin
                    state_next = EV_NODE_CHK;
                end
            end
            EV_NODE_CHK: begin
                // Node data is now valid; the feature read lands in the next cycle.
                if (node_left < 0) begin
                    if (node_right >= 0) begin
                        state_next  = EV_DONE;
                        out_st_next = ST_BAD_LEAF;
                    end else begin
                        leaf_next  = node_value;
                        state_next = EV_SCALE;
                    end
                end else if (node_right < 0 || node_feat < 0 ||
                             32'(node_feat) >= NUM_FEATURES) begin
                    state_next  = EV_DONE;
                    out_st_next = ST_BAD_SPLIT;
                end else begin
                    state_next = EV_ACCUM;
                end
            end
            EV_ACCUM: begin
                // Take the branch once the feature read has returned.
                if (nx < 0 || 32'(nx) >= 32'(total_reg)) begin
                    state_next  = EV_DONE;
                    out_st_next = ST_CHILD_RANGE;
                end else begin
                    at_next    = nx;
                    visit_next = visit_reg + 13'd1;
                    state_next = EV_NODE_RD;
                end
            end
            EV_SCALE: begin
                t = 50'(leaf_reg) * $signed({1'b0, leaf_scale}) + 50'sd32768;
                prod_next = t;
                state_next = EV_DONE;
                out_st_next = ST_TERM;
            end
            EV_DONE: begin
                if (out_st_reg == ST_TERM) begin
                    sum_next   = sat_add(sum_reg, 48'(prod_reg >>> 16));
                    tree_next  = tree_reg + 9'd1;
                    state_next = EV_TREE_RD;
                end else begin
                    out_valid_next = 1'b1;
                    out_score_next = out_st_reg == ST_OK ? sum_reg : '0;
                    state_next     = EV_IDLE;
                end
            end
            default: state_next = EV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= EV_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tree_reg      <= tree_next;
        first_reg     <= first_next;
        total_reg     <= total_next;
        visit_reg     <= visit_next;
        at_reg        <= at_next;
        sum_reg       <= sum_next;
        leaf_reg      <= leaf_next;
        prod_reg      <= prod_next;
        out_score_reg <= out_score_next;
        out_st_reg    <= out_st_next;
    end
endmodule
`default_nettype wire

FILE: rtl/boosted_tree_ensemble_scorer_top.sv
// Top level of the boosted tree ensemble scorer.
//  channel | direction | transaction
//  s_      | in        | node write, tree range write or feature value
//  m_      | out       | score, decision and status per evaluation
//  apb     | in        | initial_score, leaf_scale, score_threshold, num_trees
// Loads and features are accepted whenever the front is not stalled. After the last
// feature the tree walker reads each tree's range, then each node on the path and the
// feature it splits on, through the registered reads of the stores; a wrong feature
// count skips the walk. Reset clears control state and the configuration registers;
// the stores and datapath registers start undefined. The front stalls while an
// evaluation is queued or running; a stalled result holds in the output register.
`default_nettype none
module boosted_tree_ensemble_scorer_top #(
    parameter int unsigned NODE_DEPTH   = 4096,
    parameter int unsigned MAX_TREES    = 256,
    parameter int unsigned NUM_FEATURES = 27
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic [11:0]        s_index,
    input  wire logic signed [15:0] s_left_child,
    input  wire logic signed [15:0] s_right_child,
    input  wire logic signed [7:0]  s_split_feature,
    input  wire logic signed [31:0] s_split_threshold,
    input  wire logic signed [31:0] s_leaf_value,
    input  wire logic [12:0]        s_range_offset,
    input  wire logic [12:0]        s_range_count,
    input  wire logic signed [31:0] s_feature_value,
    input  wire logic               s_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [47:0]      m_score,
    output logic                    m_decision,
    output logic [2:0]              m_status
);
    import bte_pkg::*;
    localparam int unsigned NW = $clog2(NODE_DEPTH);
    localparam int unsigned TW = $clog2(MAX_TREES);
    localparam int unsigned FW = $clog2(NUM_FEATURES);
    localparam int unsigned NODE_W = 16 + 16 + 8 + 32 + 32;

    logic signed [47:0] init_reg, thresh_reg;
    logic [16:0] rate_reg;
    logic [8:0]  trees_reg;
    logic        cfg_we;
    logic        q_valid, q_ready, feat_we;
    logic        eval_busy;
    eval_cmd_t   q_cmd;
    logic        acc;
    logic        node_we, tree_we;
    logic [TW-1:0] tree_raddr;
    logic [NW-1:0] node_raddr;
    logic [FW-1:0] feat_raddr;
    logic [25:0] tree_rd;
    logic [NODE_W-1:0] node_rd;
    logic [31:0] feat_rd;
    logic signed [47:0] res_score;
    logic [2:0] res_status;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign acc    = s_valid && s_ready;
    assign node_we = acc && kind_t'(s_kind) == KIND_NODE && 32'(s_index) < NODE_DEPTH;
    assign tree_we = acc && kind_t'(s_kind) == KIND_RANGE && 32'(s_index) < MAX_TREES;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg   <= '0;
            rate_reg   <= 17'd65536;
            thresh_reg <= '0;
            trees_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr_t'(paddr[4:3]))
                CFG_INIT:   init_reg   <= pwdata[47:0];
                CFG_RATE:   rate_reg   <= pwdata[16:0];
                CFG_THRESH: thresh_reg <= pwdata[47:0];
                CFG_TREES:  trees_reg  <= pwdata[8:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_addr_t'(paddr[4:3]))
            CFG_INIT:   prdata = 64'(unsigned'(init_reg));
            CFG_RATE:   prdata = 64'(rate_reg);
            CFG_THRESH: prdata = 64'(unsigned'(thresh_reg));
            CFG_TREES:  prdata = 64'(trees_reg);
            default:    prdata = '0;
        endcase
    end

    bte_front #(.NUM_FEATURES(NUM_FEATURES)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_last, .s_index,
        .feat_we, .q_valid, .q_cmd, .q_ready, .eval_busy
    );

    bte_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
        .aclk, .we(node_we), .waddr(NW'(s_index)),
        .wdata({s_left_child, s_right_child, s_split_feature, s_split_threshold,
                s_leaf_value}),
        .raddr(node_raddr), .rdata(node_rd)
    );

    bte_ram #(.WIDTH(26), .DEPTH(MAX_TREES)) u_tree_ram (
        .aclk, .we(tree_we), .waddr(TW'(s_index)),
        .wdata({s_range_offset, s_range_count}), .raddr(tree_raddr), .rdata(tree_rd)
    );

    bte_ram #(.WIDTH(32), .DEPTH(NUM_FEATURES)) u_feat_ram (
        .aclk, .we(feat_we), .waddr(FW'(s_index)), .wdata(s_feature_value),
        .raddr(feat_raddr), .rdata(feat_rd)
    );

    bte_eval #(
        .NODE_DEPTH(NODE_DEPTH), .MAX_TREES(MAX_TREES), .NUM_FEATURES(NUM_FEATURES)
    ) u_eval (
        .aclk, .aresetn, .q_valid, .q_cmd, .q_ready, .busy(eval_busy),
        .initial_score(init_reg), .leaf_scale(rate_reg), .num_trees(trees_reg),
        .tree_raddr, .tree_first(tree_rd[25:13]), .tree_total(tree_rd[12:0]),
        .node_raddr,
        .node_left(node_rd[103:88]), .node_right(node_rd[87:72]),
        .node_feat(node_rd[71:64]), .node_thresh(node_rd[63:32]),
        .node_value(node_rd[31:0]),
        .feat_raddr, .feat_value(feat_rd),
        .m_valid, .m_ready, .res_score, .res_status
    );

    assign m_score    = res_score;
    assign m_status   = res_status;
    assign m_decision = res_status == ST_OK && res_score >= thresh_reg;
endmodule
`default_nettype wire

FILE: rtl/bte_checker.sv
// Port-level checker for the scorer, bound to the top level.
`default_nettype none
module bte_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [47:0] m_score,
    input wire logic        m_decision,
    input wire logic [2:0]  m_status
);
    import bte_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_score))
        else $error("result dropped while stalled");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_score == '0 && !m_decision)
        else $error("faulted result carries a score");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != ST_TERM)
        else $error("status out of range");
endmodule

bind boosted_tree_ensemble_scorer_top bte_checker u_chk (.*);
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the boosted tree ensemble scorer top level.
`timescale 1ns / 1ps
module tb;
    import bte_pkg::*;

    localparam int NODES = 4096;
    localparam int TREES = 256;
    localparam int NFEAT = 27;
    localparam longint SMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SMIN = -SMAX - 1;

    typedef struct {
        logic [1:0]         kind;
        logic [11:0]        idx;
        logic signed [15:0] lc;
        logic signed [15:0] rc;
        logic signed [7:0]  sf;
        logic signed [31:0] thr;
        logic signed [31:0] lv;
        logic [12:0]        ro;
        logic [12:0]        rn;
        logic signed [31:0] fv;
        logic               last;
    } bte_item_t;

    typedef struct {
        logic signed [47:0] raw;
        logic               dec;
        logic [2:0]         st;
    } score_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_kind = 0;
    logic [11:0] s_index = 0;
    logic signed [15:0] s_left_child = 0, s_right_child = 0;
    logic signed [7:0] s_split_feature = 0;
    logic signed [31:0] s_split_threshold = 0, s_leaf_value = 0, s_feature_value = 0;
    logic [12:0] s_range_offset = 0, s_range_count = 0;
    logic s_last = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [47:0] m_score;
    logic m_decision;
    logic [2:0] m_status;

    boosted_tree_ensemble_scorer_top dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Predictor state
    logic signed [15:0] node_l [NODES];
    logic signed [15:0] node_r [NODES];
    logic signed [7:0]  node_f [NODES];
    logic signed [31:0] node_t [NODES];
    logic signed [31:0] node_v [NODES];
    int                 rng_first [TREES];
    int                 rng_count [TREES];
    logic signed [31:0] feat [NFEAT];
    int                 seen = 0;
    longint             cfg_init = 0;
    int                 cfg_rate = 65536;
    longint             cfg_thresh = 0;
    int                 cfg_trees = 0;

    bte_item_t item_q[$];
    score_t    score_q[$];
    bte_item_t cur;
    int        in_flight = 0;
    int        mismatches = 0;
    int        gap = 0;
    int        hold = 0;
    bit        calm = 0;
    bit        feat_all = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic status_t walk_tree(input int first, input int count,
                                          output logic signed [31:0] leaf);
        int at;
        int n, l, r, f, nx;
        at = 0;
        leaf = 0;
        for (int v = 0; v < count; v++) begin
            n = first + at;
            l = node_l[n];
            r = node_r[n];
            f = node_f[n];
            if (l < 0) begin
                if (r >= 0) return ST_BAD_LEAF;
                leaf = node_v[n];
                return ST_OK;
            end
            if (r < 0 || f < 0 || f >= NFEAT) return ST_BAD_SPLIT;
            nx = (feat[f] <= node_t[n]) ? l : r;
            if (nx < 0 || nx >= count) return ST_CHILD_RANGE;
            at = nx;
        end
        return ST_NO_LEAF;
    endfunction

    function automatic void score_item(input bte_item_t it);
        status_t s;
        longint sum, term;
        logic signed [31:0] leaf;
        int first, count;
        score_t e;
        case (it.kind)
            KIND_NODE: begin
                node_l[it.idx] = it.lc;
                node_r[it.idx] = it.rc;
                node_f[it.idx] = it.sf;
                node_t[it.idx] = it.thr;
                node_v[it.idx] = it.lv;
            end
            KIND_RANGE: begin
                if (it.idx < TREES) begin
                    rng_first[it.idx] = int'(it.ro);
                    rng_count[it.idx] = int'(it.rn);
                end
            end
            KIND_FEATURE: begin
                if (it.idx < NFEAT) feat[it.idx] = it.fv;
                if (seen < 63) seen++;
                if (it.last) begin
                    s = ST_OK;
                    sum = cfg_init;
                    if (seen != NFEAT) s = ST_FEAT_COUNT;
                    for (int t = 0; t < cfg_trees && s == ST_OK; t++) begin
                        if (t >= TREES) begin
                            s = ST_TREE_RANGE;
                        end else begin
                            first = rng_first[t];
                            count = rng_count[t];
                            if (count == 0 || first > NODES || count > NODES - first) begin
                                s = ST_TREE_RANGE;
                            end else begin
                                s = walk_tree(first, count, leaf);
                                if (s == ST_OK) begin
                                    term = (longint'(leaf) * longint'(cfg_rate) + 32768) >>> 16;
                                    sum = sum + term;
                                    if (sum > SMAX) sum = SMAX;
                                    if (sum < SMIN) sum = SMIN;
                                end
                            end
                        end
                    end
                    seen = 0;
                    if (s != ST_OK) sum = 0;
                    e.raw = sum[47:0];
                    e.dec = (s == ST_OK && sum >= cfg_thresh);
                    e.st = s;
                    score_q.push_back(e);
                end
            end
            default: ;
        endcase
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                score_item(cur);
                in_flight--;
            end
            if (!s_valid || s_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_valid <= 0;
                end else if (item_q.size() > 0 && !calm && $urandom_range(0, 6) == 0) begin
                    gap <= $urandom_range(0, 5);
                    s_valid <= 0;
                end else if (item_q.size() > 0) begin
                    cur = item_q.pop_front();
                    s_kind <= cur.kind;
                    s_index <= cur.idx;
                    s_left_child <= cur.lc;
                    s_right_child <= cur.rc;
                    s_split_feature <= cur.sf;
                    s_split_threshold <= cur.thr;
                    s_leaf_value <= cur.lv;
                    s_range_offset <= cur.ro;
                    s_range_count <= cur.rn;
                    s_feature_value <= cur.fv;
                    s_last <= cur.last;
                    s_valid <= 1;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        score_t e;
        if (!aresetn) begin
            m_ready <= 0;
            hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (score_q.size() == 0) begin
                    report_mismatch("result with no evaluation pending");
                end else begin
                    e = score_q.pop_front();
                    if (m_score !== e.raw)
                        report_mismatch($sformatf("score %h, want %h", m_score, e.raw));
                    if (m_decision !== e.dec)
                        report_mismatch($sformatf("decision %b, want %b", m_decision, e.dec));
                    if (m_status !== e.st)
                        report_mismatch($sformatf("status %0d, want %0d", m_status, e.st));
                end
            end
            if (hold > 0) begin
                hold <= hold - 1;
                m_ready <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold <= $urandom_range(0, 5);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] pick48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return 48'h0;
            3: return {{16{w[31]}}, w[31:0]};
            default: return w[47:0];
        endcase
    endfunction

    function automatic bte_item_t rand_item(input logic [1:0] k);
        bte_item_t it;
        it.kind = k;
        it.idx = 12'($urandom);
        it.lc = 16'($urandom);
        it.rc = 16'($urandom);
        it.sf = 8'($urandom);
        it.thr = $urandom;
        it.lv = $urandom;
        it.ro = 13'($urandom);
        it.rn = 13'($urandom);
        it.fv = $urandom;
        it.last = 1'($urandom);
        return it;
    endfunction

    task automatic push_item(input bte_item_t it);
        bte_item_t nz;
        // sprinkle ignored or count-breaking transactions
        if ($urandom_range(0, 24) == 0) begin
            nz = rand_item($urandom_range(0, 1) ? KIND_NONE : KIND_RANGE);
            if (nz.kind == KIND_RANGE) nz.idx = 12'($urandom_range(TREES, 4095));
            item_q.push_back(nz);
            in_flight++;
        end
        if (feat_all && $urandom_range(0, 79) == 0) begin
            nz = rand_item(KIND_FEATURE);
            nz.idx = 12'($urandom_range(NFEAT, 4095));
            nz.last = 0;
            item_q.push_back(nz);
            in_flight++;
        end
        item_q.push_back(it);
        in_flight++;
    endtask

    task automatic push_feature(input int idx, input logic [31:0] v, input bit last);
        bte_item_t it;
        it = rand_item(KIND_FEATURE);
        it.idx = 12'(idx);
        it.fv = v;
        it.last = last;
        push_item(it);
    endtask

    task automatic push_range(input int t, input int first, input int count);
        bte_item_t it;
        it = rand_item(KIND_RANGE);
        it.idx = 12'(t);
        it.ro = 13'(first);
        it.rn = 13'(count);
        push_item(it);
    endtask

    // Lay out a heap-shaped tree of c nodes at base; noisy corrupts some nodes.
    task automatic build_body(input int base, input int c, input bit noisy);
        bte_item_t it;
        for (int i = 0; i < c; i++) begin
            it = rand_item(KIND_NODE);
            it.idx = 12'(base + i);
            if (2 * i + 1 < c) begin
                it.lc = 16'(2 * i + 1);
                it.rc = 16'((2 * i + 2 < c) ? 2 * i + 2 : 2 * i + 1);
                it.sf = 8'($urandom_range(0, NFEAT - 1));
                it.thr = pick32();
            end else begin
                it.lc = 16'(-$urandom_range(1, 32768));
                it.rc = 16'(-$urandom_range(1, 32768));
                it.lv = pick32();
            end
            if (noisy && $urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0: begin it.lc = -16'sd1; it.rc = 16'($urandom_range(0, 32767)); end
                    1: begin it.lc = '0; it.rc = '0; it.sf = 8'($urandom); end
                    2: begin
                        it.lc = 16'(c + $urandom_range(0, 40));
                        it.rc = it.lc;
                        it.sf = '0;
                    end
                    default: begin
                        it.lc = '0;
                        it.rc = '0;
                        it.sf = 8'($urandom_range(0, NFEAT - 1));
                    end
                endcase
            end
            push_item(it);
        end
    endtask

    task automatic push_vector(input bit noisy);
        int mode;
        int drop;
        mode = noisy ? $urandom_range(0, 5) : $urandom_range(2, 9);
        drop = $urandom_range(0, NFEAT - 1);
        for (int i = 0; i < NFEAT; i++) begin
            if (mode == 0 && i == drop) continue;
            if (mode == 3 && feat_all && i == drop)
                push_feature($urandom, pick32(), i == NFEAT - 1);
            else
                push_feature(i, pick32(), (i == NFEAT - 1) && mode != 1);
        end
        if (mode == 1) push_feature($urandom, pick32(), 1);
        else if (mode != 0) feat_all = 1;
    endtask

    task automatic cfg_write(input cfg_addr_t a, input logic [63:0] v);
        @(posedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {a, 3'b000};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (a)
            CFG_INIT:   cfg_init = longint'(signed'(v[47:0]));
            CFG_RATE:   cfg_rate = int'(v[16:0]);
            CFG_THRESH: cfg_thresh = longint'(signed'(v[47:0]));
            CFG_TREES:  cfg_trees = int'(v[8:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (in_flight > 0 || score_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        bte_item_t it;
        int trees, nb, nv, k;
        bit noisy;
        int bb[4];
        int bc[4];
        logic [47:0] w;
        aresetn <= 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: short vectors, ignored kinds and slots, extreme node fields
        push_feature(0, 32'h7FFF_FFFF, 0);
        push_feature(1, 32'h8000_0000, 0);
        push_feature(4095, 32'h0, 1);
        it = rand_item(KIND_NONE);
        it.last = 1;
        push_item(it);
        it = rand_item(KIND_NODE);
        it.idx = 12'd4095;
        it.lc = 16'sh7FFF; it.rc = 16'sh8000; it.sf = 8'sh80;
        it.thr = 32'sh8000_0000; it.lv = 32'sh7FFF_FFFF;
        push_item(it);
        it.idx = '0;
        it.lc = 16'sh8000; it.rc = 16'sh7FFF; it.sf = 8'sh7F;
        it.thr = 32'sh7FFF_FFFF; it.lv = 32'sh8000_0000;
        push_item(it);
        push_range(4095, 13'h1FFF, 13'h1FFF);
        push_range(TREES - 1, 13'h1FFF, 13'h1FFF);
        push_feature(NFEAT - 1, 32'hFFFF_FFFF, 1);
        drain();

        for (int p = 0; p < 20; p++) begin
            calm = (p >= 17);
            noisy = (p % 3 == 2);
            if (p == 0) trees = 0;
            else if (p == 6) trees = TREES;
            else if ($urandom_range(0, 7) == 0) trees = 0;
            else trees = $urandom_range(1, 8);
            cfg_write(CFG_TREES, 64'(trees));
            if (p == 0 || $urandom_range(0, 1)) begin
                w = pick48();
                cfg_write(CFG_INIT, {{16{w[47]}}, w});
            end
            if (p == 0 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0: cfg_write(CFG_RATE, 64'd0);
                    1: cfg_write(CFG_RATE, 64'd65536);
                    default: cfg_write(CFG_RATE, 64'($urandom_range(0, 65536)));
                endcase
            end
            if (p == 0 || $urandom_range(0, 1)) begin
                w = pick48();
                cfg_write(CFG_THRESH, {{16{w[47]}}, w});
            end

            nb = $urandom_range(1, 4);
            for (int b = 0; b < nb; b++) begin
                bc[b] = (p == 9) ? $urandom_range(15, 31) : $urandom_range(1, 7);
                bb[b] = $urandom_range(0, NODES - bc[b]);
                build_body(bb[b], bc[b], noisy);
            end
            for (int t = 0; t < trees; t++) begin
                k = $urandom_range(0, nb - 1);
                if (noisy && $urandom_range(0, 9) == 0) begin
                    // a range that is empty or runs off the node store
                    it.ro = 13'($urandom);
                    it.rn = 13'($urandom);
                    if (it.rn != 0 && it.ro <= NODES && it.rn <= NODES - it.ro) it.rn = '0;
                    push_range(t, int'(it.ro), int'(it.rn));
                end else begin
                    push_range(t, bb[k], bc[k]);
                end
            end
            nv = $urandom_range(1, 3);
            for (int v = 0; v < nv; v++) push_vector(noisy);
            drain();
        end

        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("boosted_tree_ensemble_scorer_top verification clean");
        end else begin
            $display("boosted_tree_ensemble_scorer_top verification failed");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("boosted_tree_ensemble_scorer_top verification failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/bte_pkg.sv
rtl/bte_ram.sv
rtl/bte_front.sv
rtl/bte_eval.sv
rtl/boosted_tree_ensemble_scorer_top.sv
rtl/bte_checker.sv
verif/tb.sv
